[sv/sssp_pkg.sv]
`default_nettype none
package sssp_pkg;
    localparam int NODES = 32;
    localparam int NODE_BITS = 5;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS = 21;
    // one edge-store row: all costs of a source node, present bits on top
    localparam int ROW_BITS = NODES * WEIGHT_BITS + NODES;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        logic                   init;
        logic [NODE_BITS-1:0]   start;
        logic                   mark;
        logic [NODE_BITS-1:0]   visit;
        logic                   relax;
        logic [DIST_BITS-1:0]   base;
        logic [NODES-1:0]       edge_row;
        logic [NODES*WEIGHT_BITS-1:0] cost_row;
    } cell_ctl_t;

    typedef struct packed {
        logic                   found;
        logic [NODE_BITS-1:0]   idx;
        logic [DIST_BITS-1:0]   dval;
    } cand_t;
endpackage
`default_nettype wire

[sv/sssp_cell.sv]
`default_nettype none
module sssp_cell
    import sssp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [NODE_BITS-1:0]  my_index,
    input  wire cell_ctl_t             ctl,
    input  wire cand_t                 cand_in,
    output cand_t                      cand_out,
    output logic [DIST_BITS-1:0]       dist_out,
    output logic                       reached
);
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic reached_reg, reached_next, visited_reg, visited_next;
    cand_t cand_reg, cand_next;
    logic [WEIGHT_BITS-1:0] w;
    logic [DIST_BITS-1:0] nd;
    logic mine;

    always_comb begin
        w = ctl.cost_row[my_index*WEIGHT_BITS +: WEIGHT_BITS];
        nd = ctl.base + DIST_BITS'(w);
        mine = reached_reg && !visited_reg;
        dist_next = dist_reg;
        reached_next = reached_reg;
        visited_next = visited_reg;
        if (ctl.init) begin
            reached_next = (ctl.start == my_index);
            visited_next = 1'b0;
            dist_next = '0;
        end else begin
            if (ctl.mark && ctl.visit == my_index) visited_next = 1'b1;
            if (ctl.relax && ctl.edge_row[my_index]
                && (!reached_reg || nd < dist_reg)) begin
                reached_next = 1'b1;
                dist_next = nd;
            end
        end
        // take equal distances too while moving toward index 0: lowest index wins ties
        cand_next = cand_in;
        if (mine && (!cand_in.found || dist_reg <= cand_in.dval)) begin
            cand_next.found = 1'b1;
            cand_next.idx = my_index;
            cand_next.dval = dist_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reached_reg <= 1'b0;
            visited_reg <= 1'b0;
        end else begin
            reached_reg <= reached_next;
            visited_reg <= visited_next;
        end
        dist_reg <= dist_next;
        cand_reg <= cand_next;
    end
    assign cand_out = cand_reg;
    assign dist_out = dist_reg;
    assign reached = reached_reg;
endmodule
`default_nettype wire

[sv/single_source_shortest_path_top.sv]
`default_nettype none
// Shortest-path engine for a 32-node directed graph with 16-bit edge weights.
// Input stream s_*: s_tuser = req_type; s_tdata = src_node, dst_node,
// edge_weight, start_node from bit 0 up. req_type 0 clears all edges and 1 loads
// one edge, keeping the smaller weight of a repeated pair; both may follow
// back to back. 2 starts a run; 3 is dropped.
// A run holds s_tready low: an init state, then per visited node a select phase
// (candidates advance one cell per cycle down the chain to node 0), a row read
// state and a relax state, then a final select phase before the first result.
// Then 32 result transfers on m_*, one per node in index order, tlast on the
// last one; m_tdata = node_index, distance, reached from bit 0 up.
// s_tready returns the cycle after the last result transfer.
// Edge rows live in a 32-row memory with one read and one write port; a load
// reads its row, then merges and writes it back the next cycle.
// A stalled receiver holds the current result; nothing is lost.
// Reset clears the 32 row-valid bits, so the edge store reads empty, and
// returns to idle.
module single_source_shortest_path_top
    import sssp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // src_node, dst_node, edge_weight, start_node, zero pad
    input  wire logic [1:0]  s_tuser,  // req_type
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [31:0]      m_tdata,  // node_index, distance, reached, zero pad
    output logic             m_tlast
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001, ST_INIT = 6'b000010, ST_SEL = 6'b000100,
        ST_READ = 6'b001000, ST_RELAX = 6'b010000, ST_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [ROW_BITS-1:0] cost_mem [NODES];
    logic [NODES-1:0] row_valid_reg;
    logic [NODE_BITS-1:0] start_reg, u_reg, u_next, out_reg, out_next;
    logic [DIST_BITS-1:0] base_reg, base_next;
    logic [NODE_BITS:0] rnd_reg, rnd_next;
    logic [NODE_BITS:0] sel_cnt_reg, sel_cnt_next;

    req_t req;
    logic [NODE_BITS-1:0] src, dst, st;
    logic [WEIGHT_BITS-1:0] wgt;
    logic acc;
    cell_ctl_t ctl;
    cand_t chain [NODES+1];
    logic [DIST_BITS-1:0] node_dist [NODES];
    logic [NODES-1:0] rch;

    logic [ROW_BITS-1:0] ld_row_reg, wr_row_reg, old_row, new_row;
    logic [NODE_BITS-1:0] ld_src_reg, ld_dst_reg, wr_src_reg;
    logic [WEIGHT_BITS-1:0] ld_w_reg, old_w;
    logic [NODES-1:0] old_bits;
    logic ld_pend_reg, ld_valid_reg, wr_vld_reg, old_present;

    assign req = req_t'(s_tuser);
    assign src = s_tdata[4:0];
    assign dst = s_tdata[9:5];
    assign wgt = s_tdata[25:10];
    assign st  = s_tdata[30:26];
    assign s_tready = (state_reg == ST_IDLE);
    assign acc = s_tvalid && s_tready;

    // row-valid bits: a clear drops every row at once, a load claims its row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (acc && req == REQ_CLEAR) begin
            row_valid_reg <= '0;
        end else if (acc && req == REQ_LOAD) begin
            row_valid_reg[src] <= 1'b1;
        end
    end

    // merge a load into its row; a row written on the previous edge is
    // forwarded since the memory read missed it
    always_comb begin
        old_row = (wr_vld_reg && wr_src_reg == ld_src_reg) ? wr_row_reg : ld_row_reg;
        old_bits = ld_valid_reg ? old_row[ROW_BITS-1 -: NODES] : '0;
        old_w = old_row[ld_dst_reg*WEIGHT_BITS +: WEIGHT_BITS];
        old_present = old_bits[ld_dst_reg];
        new_row = old_row;
        new_row[ROW_BITS-1 -: NODES] = old_bits;
        new_row[NODES*WEIGHT_BITS + ld_dst_reg] = 1'b1;
        if (!old_present || ld_w_reg < old_w)
            new_row[ld_dst_reg*WEIGHT_BITS +: WEIGHT_BITS] = ld_w_reg;
    end

    // load is read-modify-write: read row now, write next cycle
    always_ff @(posedge aclk) begin
        ld_row_reg <= cost_mem[(acc && req == REQ_LOAD) ? src : u_reg];
        if (ld_pend_reg) begin
            cost_mem[ld_src_reg] <= new_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_pend_reg <= 1'b0;
            wr_vld_reg <= 1'b0;
        end else begin
            ld_pend_reg <= acc && req == REQ_LOAD;
            wr_vld_reg <= ld_pend_reg;
        end
        ld_src_reg <= src;
        ld_dst_reg <= dst;
        ld_w_reg <= wgt;
        ld_valid_reg <= row_valid_reg[src];
        wr_row_reg <= new_row;
        wr_src_reg <= ld_src_reg;
    end

    always_comb begin
        state_next = state_reg;
        u_next = u_reg;
        base_next = base_reg;
        rnd_next = rnd_reg;
        out_next = out_reg;
        sel_cnt_next = sel_cnt_reg;
        ctl = '0;
        ctl.start = start_reg;
        ctl.visit = u_reg;
        ctl.base = base_reg;
        ctl.edge_row = row_valid_reg[u_reg] ? ld_row_reg[ROW_BITS-1 -: NODES] : '0;
        ctl.cost_row = ld_row_reg[NODES*WEIGHT_BITS-1:0];
        case (state_reg)
            ST_IDLE: if (acc && req == REQ_RUN) state_next = ST_INIT;
            ST_INIT: begin
                ctl.init = 1'b1;
                rnd_next = '0;
                sel_cnt_next = '0;
                state_next = ST_SEL;
            end
            ST_SEL: begin
                // hold until the candidate has rippled through every cell
                if (sel_cnt_reg != (NODE_BITS+1)'(NODES)) begin
                    sel_cnt_next = sel_cnt_reg + 1'b1;
                end else if (!chain[0].found || rnd_reg == (NODE_BITS+1)'(NODES)) begin
                    state_next = ST_OUT;
                    out_next = '0;
                end else begin
                    u_next = chain[0].idx;
                    base_next = chain[0].dval;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ctl.mark = 1'b1;
                state_next = ST_RELAX;
            end
            ST_RELAX: begin
                ctl.relax = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                sel_cnt_next = '0;
                state_next = ST_SEL;
            end
            ST_OUT: if (m_tready) begin
                out_next = out_reg + 1'b1;
                if (out_reg == NODE_BITS'(NODES-1)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
        if (acc) start_reg <= st;
        u_reg <= u_next;
        base_reg <= base_next;
        rnd_reg <= rnd_next;
        out_reg <= out_next;
        sel_cnt_reg <= sel_cnt_next;
    end

    assign chain[NODES] = '0;
    for (genvar g = 0; g < NODES; g++) begin : g_cell
        sssp_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .my_index(NODE_BITS'(g)),
            .ctl(ctl), .cand_in(chain[g+1]), .cand_out(chain[g]),
            .dist_out(node_dist[g]), .reached(rch[g])
        );
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast = (out_reg == NODE_BITS'(NODES-1));
    assign m_tdata = {5'd0, rch[out_reg],
                      rch[out_reg] ? node_dist[out_reg] : {DIST_BITS{1'b0}}, out_reg};
endmodule
`default_nettype wire

[test/tb_single_source_shortest_path_top.sv]
`default_nettype none
module tb_single_source_shortest_path_top;
    import sssp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NODE_BITS-1:0]   node;
        logic [DIST_BITS-1:0]   dval;
        logic                   hit;
        logic                   last;
    } node_dist_t;

    typedef struct {
        req_t                   kind;
        logic [NODE_BITS-1:0]   src;
        logic [NODE_BITS-1:0]   dst;
        logic [WEIGHT_BITS-1:0] weight;
        logic [NODE_BITS-1:0]   start;
    } graph_req_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // src_node, dst_node, edge_weight, start_node, zero pad
    logic [1:0]  s_tuser;   // req_type
    logic        m_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;   // node_index, distance, reached, zero pad
    logic        m_tlast;

    single_source_shortest_path_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Predictor copy of the graph
    logic                   adj_present [NODES][NODES];
    logic [WEIGHT_BITS-1:0] adj_cost    [NODES][NODES];

    graph_req_t pending_reqs[$];
    node_dist_t expected_dists[$];

    int  errors = 0;
    int  send_idle_pct = 24;
    int  recv_idle_pct = 70;
    bit  hold_send = 0;
    bit  stim_done = 0;
    int  quiet_cycles = 0;

    localparam int QUIET_LIMIT = 20000;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the graph copy; push distances for a run.
    task automatic predict_paths(input graph_req_t r);
        logic [63:0] path_len [NODES];
        logic        seen [NODES];
        logic        done [NODES];
        logic [63:0] nd;
        int u;
        bit found;
        case (r.kind)
            REQ_CLEAR: begin
                foreach (adj_present[i, j]) adj_present[i][j] = 0;
            end
            REQ_LOAD: begin
                if (!adj_present[r.src][r.dst] || r.weight < adj_cost[r.src][r.dst])
                    adj_cost[r.src][r.dst] = r.weight;
                adj_present[r.src][r.dst] = 1;
            end
            REQ_RUN: begin
                for (int i = 0; i < NODES; i++) begin
                    path_len[i] = 0; seen[i] = 0; done[i] = 0;
                end
                seen[r.start] = 1;
                for (int round = 0; round < NODES; round++) begin
                    found = 0;
                    u = 0;
                    for (int i = 0; i < NODES; i++) begin
                        if (seen[i] && !done[i] && (!found || path_len[i] < path_len[u])) begin
                            found = 1;
                            u = i;
                        end
                    end
                    if (!found) break;
                    done[u] = 1;
                    for (int v = 0; v < NODES; v++) begin
                        if (adj_present[u][v]) begin
                            nd = path_len[u] + adj_cost[u][v];
                            if (!seen[v] || nd < path_len[v]) begin
                                seen[v] = 1;
                                path_len[v] = nd;
                            end
                        end
                    end
                end
                for (int i = 0; i < NODES; i++) begin
                    expected_dists.push_back('{node: i[NODE_BITS-1:0],
                        dval: seen[i] ? path_len[i][DIST_BITS-1:0] : '0,
                        hit: seen[i], last: (i == NODES - 1)});
                end
            end
            default: ;
        endcase
    endtask

    function automatic graph_req_t make_req(req_t k, int s, int d, int w, int st);
        graph_req_t r;
        r.kind = k;
        r.src = s[NODE_BITS-1:0];
        r.dst = d[NODE_BITS-1:0];
        r.weight = w[WEIGHT_BITS-1:0];
        r.start = st[NODE_BITS-1:0];
        return r;
    endfunction

    // Queue a random graph: a clear, random edges (some pairs repeated), then runs.
    task automatic add_random_graph(input int n_edges, input int n_runs, input int max_w);
        graph_req_t r;
        pending_reqs.push_back(make_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
        for (int i = 0; i < n_edges; i++) begin
            r = make_req(REQ_LOAD, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                         $urandom_range(0, max_w), $urandom);
            pending_reqs.push_back(r);
            // sometimes repeat the pair with another weight
            if ($urandom_range(0, 9) == 0) begin
                r.weight = WEIGHT_BITS'($urandom_range(0, max_w));
                pending_reqs.push_back(r);
            end
        end
        if ($urandom_range(0, 7) == 0)
            pending_reqs.push_back(make_req(REQ_NONE, $urandom, $urandom, $urandom, $urandom));
        for (int i = 0; i < n_runs; i++)
            pending_reqs.push_back(make_req(REQ_RUN, $urandom, $urandom, $urandom,
                                            $urandom_range(0, NODES - 1)));
    endtask

    // Driver: pop the next request once the current transfer is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                graph_req_t r;
                r = pending_reqs.pop_front();
                predict_paths(r);
                s_tvalid <= 1;
                s_tuser  <= r.kind;
                s_tdata  <= {1'b0, r.start, r.weight, r.dst, r.src};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                node_dist_t got, want;
                got = '{node: m_tdata[4:0], dval: m_tdata[25:5], hit: m_tdata[26],
                        last: m_tlast};
                if (expected_dists.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    errors++;
                end else begin
                    want = expected_dists.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        foreach (adj_present[i, j]) begin
            adj_present[i][j] = 0;
            adj_cost[i][j] = '0;
        end
        aresetn = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;

        // Directed part: empty graph, extremes, repeated edge, ties, unused request.
        pending_reqs.push_back(make_req(REQ_RUN, 31, 31, 65535, 0));
        pending_reqs.push_back(make_req(REQ_LOAD, 0, 31, 65535, 31));
        pending_reqs.push_back(make_req(REQ_LOAD, 31, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_LOAD, 0, 31, 100, 0));     // smaller wins
        pending_reqs.push_back(make_req(REQ_LOAD, 0, 31, 200, 0));     // larger kept out
        pending_reqs.push_back(make_req(REQ_LOAD, 0, 1, 50, 0));
        pending_reqs.push_back(make_req(REQ_LOAD, 0, 2, 50, 0));       // tie with node 1
        pending_reqs.push_back(make_req(REQ_LOAD, 1, 3, 10, 0));
        pending_reqs.push_back(make_req(REQ_LOAD, 2, 3, 10, 0));
        pending_reqs.push_back(make_req(REQ_LOAD, 5, 5, 7, 0));        // self loop
        pending_reqs.push_back(make_req(REQ_NONE, 31, 31, 65535, 31)); // dropped
        pending_reqs.push_back(make_req(REQ_RUN, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_RUN, 0, 0, 0, 31));
        pending_reqs.push_back(make_req(REQ_RUN, 0, 0, 0, 5));
        for (int i = 0; i < 31; i++)
            pending_reqs.push_back(make_req(REQ_LOAD, i, i + 1, 65535, 0));
        pending_reqs.push_back(make_req(REQ_RUN, 0, 0, 0, 0));         // long path, wide sum
        pending_reqs.push_back(make_req(REQ_CLEAR, 31, 31, 65535, 31));
        pending_reqs.push_back(make_req(REQ_RUN, 0, 0, 0, 0));

        // Random phases, each idling pattern in turn.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 70;
                recv_idle_pct = 24;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int g = 0; g < 5; g++)
                add_random_graph($urandom_range(5, 44), $urandom_range(1, 2),
                                 ($urandom_range(0, 1) != 0) ? 65535 : 15);
            // hold off until every pending result has drained
            wait (pending_reqs.size() == 0);
            hold_send = 1;
            wait (expected_dists.size() == 0);
            @(posedge aclk);
            hold_send = 0;
        end

        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_dists.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
